/* rtl/core/adcrs_pkg.sv */
package adcrs_pkg;

    typedef enum logic [2:0] {
        ACT_ALL_HIGH = 3'd0,
        ACT_SHIFT    = 3'd1,
        ACT_BYTE     = 3'd2,
        ACT_SAMPLE   = 3'd3,
        ACT_CH_ERR   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CFG_SINGLE_ENDED_MASK = 2'd0,
        CFG_CHANNEL_COUNT     = 2'd1,
        CFG_ADC_COUNT         = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        VAL_ZERO   = 2'd0,
        VAL_ONE    = 2'd1,
        VAL_CMD_HI = 2'd2,
        VAL_CMD_LO = 2'd3
    } val_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_CH_ERR,
        ST_ALL_HIGH,
        ST_SHIFT_ZERO,
        ST_SHIFT_ONE,
        ST_BYTE_HI,
        ST_BYTE_LO,
        ST_BYTE_ZERO
    } state_t;

    // command word bits
    localparam logic [15:0] CMD_START      = 16'h0400;
    localparam logic [15:0] CMD_SINGLE     = 16'h0200;
    localparam logic [7:0]  SAMPLE_HI_MASK = 8'h0F;

    typedef struct packed {
        logic       operation;
        logic [7:0] adc_select;
        logic [2:0] channel;
        logic [7:0] resp_mid_byte;
        logic [7:0] resp_low_byte;
    } in_item_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  bit_or_byte;
        logic [11:0] sample;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic      take;
        logic      emit;
        action_t   act;
        val_kind_t val;
        logic      last;
        logic      pos_one;
        logic      pos_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic is_resp;
        logic ch_err;
        logic sel_bad;
        logic need_reset;
        logic sel_bad_reg;
        logic pos_lt_sel;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/adcrs_datapath.sv */
module adcrs_datapath #(
    parameter int MAX_ADCS     = 8,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  adcrs_pkg::in_item_t  in_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output adcrs_pkg::out_item_t out_data,
    input  adcrs_pkg::dp_cmd_t   cmd,
    output adcrs_pkg::dp_status_t status
);

    localparam logic [3:0] ADC_LIMIT = 4'(MAX_ADCS);
    localparam logic [3:0] CH_LIMIT  = 4'(MAX_CHANNELS);

    logic [7:0] mask_reg;
    logic [3:0] ccount_reg;
    logic [3:0] acount_reg;
    logic [3:0] cur_reg;
    logic [3:0] pos_reg;
    logic [7:0] sel_reg;
    logic [2:0] ch_reg;
    logic [11:0] smp_reg;
    logic       sel_bad_reg;
    logic       out_valid_reg;
    adcrs_pkg::out_item_t out_reg;

    logic [3:0]  ccount_eff;
    logic [3:0]  acount_eff;
    logic        ch_err;
    logic        sel_bad;
    logic [15:0] cmd_word;
    logic [7:0]  val_byte;

    assign ccount_eff = (ccount_reg > CH_LIMIT) ? CH_LIMIT : ccount_reg;
    assign acount_eff = (acount_reg > ADC_LIMIT) ? ADC_LIMIT : acount_reg;
    assign ch_err     = {1'b0, in_data.channel} >= ccount_eff;
    assign sel_bad    = (in_data.adc_select == 8'd0)
                        || (in_data.adc_select > {4'b0, acount_eff});

    assign cmd_word = adcrs_pkg::CMD_START
                      | (mask_reg[ch_reg] ? adcrs_pkg::CMD_SINGLE : 16'h0000)
                      | {7'b0, ch_reg, 6'b0};

    always_comb
    begin
        case (cmd.val)
            adcrs_pkg::VAL_ONE:    val_byte = 8'd1;
            adcrs_pkg::VAL_CMD_HI: val_byte = cmd_word[15:8];
            adcrs_pkg::VAL_CMD_LO: val_byte = cmd_word[7:0];
            default:               val_byte = 8'd0;
        endcase
    end

    assign status.is_resp     = in_data.operation;
    assign status.ch_err      = ch_err;
    assign status.sel_bad     = sel_bad;
    assign status.need_reset  = (cur_reg == 4'd0) || ({4'b0, cur_reg} >= in_data.adc_select);
    assign status.sel_bad_reg = sel_bad_reg;
    assign status.pos_lt_sel  = {4'b0, pos_reg} < sel_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 8'hFF;
            ccount_reg    <= 4'd8;
            acount_reg    <= 4'd8;
            cur_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    adcrs_pkg::CFG_SINGLE_ENDED_MASK: mask_reg   <= cfg_data;
                    adcrs_pkg::CFG_CHANNEL_COUNT:     ccount_reg <= cfg_data[3:0];
                    adcrs_pkg::CFG_ADC_COUNT:         acount_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            // selection is decided at accept, so the converter is updated here
            if (cmd.take && !in_data.operation && !ch_err)
                cur_reg <= sel_bad ? 4'd0 : in_data.adc_select[3:0];
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pos_reg     <= cur_reg;
            sel_reg     <= in_data.adc_select;
            ch_reg      <= in_data.channel;
            smp_reg     <= {in_data.resp_mid_byte[3:0] & adcrs_pkg::SAMPLE_HI_MASK[3:0],
                            in_data.resp_low_byte};
            sel_bad_reg <= sel_bad;
        end
        else if (cmd.pos_one)
            pos_reg <= 4'd1;
        else if (cmd.pos_inc)
            pos_reg <= pos_reg + 4'd1;
        if (cmd.emit)
        begin
            out_reg.action      <= cmd.act;
            out_reg.bit_or_byte <= val_byte;
            out_reg.sample      <= (cmd.act == adcrs_pkg::ACT_SAMPLE) ? smp_reg : 12'd0;
            out_reg.last        <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/core/adcrs_ctrl.sv */
module adcrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  adcrs_pkg::dp_status_t status,
    output adcrs_pkg::dp_cmd_t    cmd
);

    adcrs_pkg::state_t state_reg;
    adcrs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= adcrs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.act    = adcrs_pkg::ACT_ALL_HIGH;
        cmd.val    = adcrs_pkg::VAL_ZERO;
        unique case (state_reg)
            adcrs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.is_resp)
                        state_next = adcrs_pkg::ST_SAMPLE;
                    else if (status.ch_err)
                        state_next = adcrs_pkg::ST_CH_ERR;
                    else if (status.sel_bad || status.need_reset)
                        state_next = adcrs_pkg::ST_ALL_HIGH;
                    else
                        state_next = adcrs_pkg::ST_SHIFT_ONE;
                end
            end
            adcrs_pkg::ST_SAMPLE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = adcrs_pkg::ACT_SAMPLE;
                    cmd.last   = 1'b1;
                    state_next = adcrs_pkg::ST_IDLE;
                end
            end
            adcrs_pkg::ST_CH_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = adcrs_pkg::ACT_CH_ERR;
                    cmd.last   = 1'b1;
                    state_next = adcrs_pkg::ST_IDLE;
                end
            end
            adcrs_pkg::ST_ALL_HIGH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = adcrs_pkg::ACT_ALL_HIGH;
                    // invalid converter: deselect only, then straight to the command
                    state_next = status.sel_bad_reg ? adcrs_pkg::ST_BYTE_HI
                                                    : adcrs_pkg::ST_SHIFT_ZERO;
                end
            end
            adcrs_pkg::ST_SHIFT_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.act     = adcrs_pkg::ACT_SHIFT;
                    cmd.pos_one = 1'b1;
                    state_next  = adcrs_pkg::ST_SHIFT_ONE;
                end
            end
            adcrs_pkg::ST_SHIFT_ONE:
            begin
                if (!status.pos_lt_sel)
                    state_next = adcrs_pkg::ST_BYTE_HI;
                else if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.act     = adcrs_pkg::ACT_SHIFT;
                    cmd.val     = adcrs_pkg::VAL_ONE;
                    cmd.pos_inc = 1'b1;
                end
            end
            adcrs_pkg::ST_BYTE_HI:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = adcrs_pkg::ACT_BYTE;
                    cmd.val    = adcrs_pkg::VAL_CMD_HI;
                    state_next = adcrs_pkg::ST_BYTE_LO;
                end
            end
            adcrs_pkg::ST_BYTE_LO:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = adcrs_pkg::ACT_BYTE;
                    cmd.val    = adcrs_pkg::VAL_CMD_LO;
                    state_next = adcrs_pkg::ST_BYTE_ZERO;
                end
            end
            adcrs_pkg::ST_BYTE_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.act    = adcrs_pkg::ACT_BYTE;
                    cmd.last   = 1'b1;
                    state_next = adcrs_pkg::ST_IDLE;
                end
            end
            default:
                state_next = adcrs_pkg::ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/adc_read_sequencer_with_cs_chain.sv */
// read sequencer for 12-bit spi converters whose selects sit on a shift chain
// in channel (in_valid/in_ready/in_data): a read request or a response.
// out channel (out_valid/out_ready/out_data): chain actions, spi bytes,
// samples and channel errors, with last set on the final one of a request.
// cfg port: cfg_we writes cfg_data into register cfg_index;
// index 0 single-ended mask, 1 channel count, 2 converter count.
// one request is worked at a time; in_ready is high only while idle.
// a response or channel error passes via its fsm state into the output register.
// a read emits all-high and a 0 shift when the chain must restart, then up to
// MAX_ADCS-1 one shifts and three bytes; a bad select gives all-high and bytes.
// the sequencer fsm gives one item per cycle while the receiver is ready, but
// none at accept or on leaving the shift loop: at most MAX_ADCS+4 items.
// a stalled receiver holds the output register and the fsm waits before its next item.
// reset sets mask 0xff, both counts to 8 and the current converter to none.
module adc_read_sequencer_with_cs_chain #(
    parameter int MAX_ADCS     = 8,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adcrs_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output adcrs_pkg::out_item_t out_data
);

    adcrs_pkg::dp_cmd_t    cmd;
    adcrs_pkg::dp_status_t status;

    adcrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    adcrs_datapath #(
        .MAX_ADCS     (MAX_ADCS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* sim/adcrs_checker.sv */
`timescale 1ns / 100ps

// watches both channels and the register port, predicts the action stream of every
// accepted request and compares each accepted result with the oldest planned one
module adcrs_checker #(
    parameter int MAX_ADCS     = 8,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  adcrs_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  adcrs_pkg::out_item_t out_data,
    output int                   fail_count,
    output int                   pending,
    output int                   request_count,
    output int                   result_count
);

    localparam int REPORT_LINES = 20;

    logic [7:0]           se_mask;
    logic [3:0]           chan_count;
    logic [3:0]           conv_count;
    logic [3:0]           sel_adc;
    adcrs_pkg::out_item_t planned_actions[$];
    adcrs_pkg::out_item_t due_item;
    adcrs_pkg::out_item_t seen_item;

    task automatic report_mismatch(input string msg);
        if (fail_count < REPORT_LINES)
        begin
            $display("checker @%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic add_action(input adcrs_pkg::action_t act, input logic [7:0] val,
                              input logic [11:0] smp);
        adcrs_pkg::out_item_t item;
        item.action      = act;
        item.bit_or_byte = val;
        item.sample      = smp;
        item.last        = 1'b0;
        planned_actions.push_back(item);
    endtask

    task automatic plan_actions(input adcrs_pkg::in_item_t req);
        logic [3:0]  ch_lim;
        logic [3:0]  adc_lim;
        logic [3:0]  pos;
        logic [15:0] cmd;
        ch_lim  = (chan_count > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : chan_count;
        adc_lim = (conv_count > MAX_ADCS) ? 4'(MAX_ADCS) : conv_count;
        if (req.operation)
        begin
            // response: only the low nibble of the middle byte counts
            add_action(adcrs_pkg::ACT_SAMPLE, 8'h00,
                       {4'(req.resp_mid_byte & adcrs_pkg::SAMPLE_HI_MASK),
                        req.resp_low_byte});
        end
        else if ({1'b0, req.channel} >= ch_lim)
        begin
            add_action(adcrs_pkg::ACT_CH_ERR, 8'h00, 12'h000);
        end
        else
        begin
            if (req.adc_select == 8'd0 || req.adc_select > {4'b0, adc_lim})
            begin
                // bad converter: deselect everything, bytes still go out
                add_action(adcrs_pkg::ACT_ALL_HIGH, 8'h00, 12'h000);
                sel_adc = 4'd0;
            end
            else
            begin
                pos = sel_adc;
                // chain restarts when nothing is selected or the target is not beyond the current one
                if (pos == 4'd0 || {4'b0, pos} >= req.adc_select)
                begin
                    add_action(adcrs_pkg::ACT_ALL_HIGH, 8'h00, 12'h000);
                    add_action(adcrs_pkg::ACT_SHIFT, 8'h00, 12'h000);
                    pos = 4'd1;
                end
                while ({4'b0, pos} < req.adc_select)
                begin
                    add_action(adcrs_pkg::ACT_SHIFT, 8'h01, 12'h000);
                    pos++;
                end
                sel_adc = req.adc_select[3:0];
            end
            cmd = adcrs_pkg::CMD_START
                | (se_mask[req.channel] ? adcrs_pkg::CMD_SINGLE : 16'h0000)
                | (16'(req.channel) << 6);
            add_action(adcrs_pkg::ACT_BYTE, cmd[15:8], 12'h000);
            add_action(adcrs_pkg::ACT_BYTE, cmd[7:0], 12'h000);
            add_action(adcrs_pkg::ACT_BYTE, 8'h00, 12'h000);
        end
        planned_actions[planned_actions.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_mask       = 8'hFF;
            chan_count    = 4'd8;
            conv_count    = 4'd8;
            sel_adc       = 4'd0;
            fail_count    = 0;
            request_count = 0;
            result_count  = 0;
            planned_actions.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    adcrs_pkg::CFG_SINGLE_ENDED_MASK: se_mask    = cfg_data;
                    adcrs_pkg::CFG_CHANNEL_COUNT:     chan_count = cfg_data[3:0];
                    adcrs_pkg::CFG_ADC_COUNT:         conv_count = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                result_count++;
                seen_item = out_data;
                if (planned_actions.size() == 0)
                begin
                    report_mismatch($sformatf("result action %0d with nothing expected",
                                              seen_item.action));
                end
                else
                begin
                    due_item = planned_actions.pop_front();
                    if (seen_item.action !== due_item.action)
                        report_mismatch($sformatf("action got %0d want %0d",
                                                  seen_item.action, due_item.action));
                    if (seen_item.bit_or_byte !== due_item.bit_or_byte)
                        report_mismatch($sformatf("bit_or_byte got %h want %h",
                                                  seen_item.bit_or_byte,
                                                  due_item.bit_or_byte));
                    if (seen_item.sample !== due_item.sample)
                        report_mismatch($sformatf("sample got %h want %h",
                                                  seen_item.sample, due_item.sample));
                    if (seen_item.last !== due_item.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  seen_item.last, due_item.last));
                end
            end
            if (in_valid && in_ready)
            begin
                request_count++;
                plan_actions(in_data);
            end
            pending <= planned_actions.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam logic OP_READ      = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;
    localparam int   STALL_LIMIT  = 3000;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   SETTLE       = 20;
    localparam int   DRAIN        = 30;
    localparam int   PHASE_ITEMS  = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = adcrs_pkg::CFG_SINGLE_ENDED_MASK;
    logic [7:0]           cfg_data  = 8'h00;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    adcrs_pkg::in_item_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    adcrs_pkg::out_item_t out_data;

    int   fail_count;
    int   pending;
    int   request_count;
    int   result_count;
    int   idle_pct       = 15;
    logic hold_req       = 1'b0;
    int   stall_cycles   = 0;
    int   settings_used  = 1;

    always #2 clk = ~clk;

    adc_read_sequencer_with_cs_chain i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    adcrs_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .request_count (request_count),
        .result_count  (result_count)
    );

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        bit hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    function automatic adcrs_pkg::in_item_t read_req(input logic [7:0] sel,
                                                     input logic [2:0] ch);
        adcrs_pkg::in_item_t it;
        it.operation     = OP_READ;
        it.adc_select    = sel;
        it.channel       = ch;
        it.resp_mid_byte = 8'($urandom_range(255));
        it.resp_low_byte = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic adcrs_pkg::in_item_t response(input logic [7:0] mid,
                                                     input logic [7:0] low);
        adcrs_pkg::in_item_t it;
        it.operation     = OP_RESPONSE;
        it.adc_select    = 8'($urandom_range(255));
        it.channel       = 3'($urandom_range(7));
        it.resp_mid_byte = mid;
        it.resp_low_byte = low;
        return it;
    endfunction

    // mostly reads of real converters, some responses, some bad selects
    function automatic adcrs_pkg::in_item_t random_item();
        int          pick;
        logic [7:0]  sel;
        pick = $urandom_range(99);
        if (pick < 30)
            return response(8'($urandom_range(255)), 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 80)
            sel = 8'($urandom_range(1, 8));
        else if (pick < 90)
            sel = 8'd0;
        else
            sel = 8'($urandom_range(255));
        return read_req(sel, 3'($urandom_range(7)));
    endfunction

    task automatic send_request(input adcrs_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] mask, input logic [7:0] chans,
                                input logic [7:0] adcs);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= adcrs_pkg::CFG_SINGLE_ENDED_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= adcrs_pkg::CFG_CHANNEL_COUNT;
        cfg_data  <= chans;
        @(posedge clk);
        cfg_index <= adcrs_pkg::CFG_ADC_COUNT;
        cfg_data  <= adcs;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: chain walk up, walk back, bad selects, sample edges
        send_request(read_req(8'd1, 3'd0));
        send_request(read_req(8'd8, 3'd7));
        send_request(read_req(8'd8, 3'd7));
        send_request(read_req(8'd3, 3'd1));
        send_request(read_req(8'd5, 3'd6));
        send_request(read_req(8'd0, 3'd2));
        send_request(read_req(8'd2, 3'd3));
        send_request(read_req(8'd9, 3'd4));
        send_request(read_req(8'd255, 3'd5));
        send_request(response(8'hFF, 8'hFF));
        send_request(response(8'h00, 8'h00));
        send_request(response(8'hF0, 8'hA5));
        send_request(response(8'h0F, 8'h00));

        // four channels, one converter, all differential
        write_config(8'h00, 8'd4, 8'd1);
        send_request(read_req(8'd1, 3'd3));
        send_request(read_req(8'd1, 3'd4));
        send_request(read_req(8'd1, 3'd7));
        send_request(read_req(8'd1, 3'd0));
        send_request(read_req(8'd2, 3'd1));

        // zero counts reject every channel
        write_config(8'hA5, 8'd0, 8'd0);
        send_request(read_req(8'd1, 3'd0));
        send_request(read_req(8'd0, 3'd0));
        send_request(response(8'h5A, 8'h3C));

        // counts above the maximum clamp, high data bits dropped
        write_config(8'h5A, 8'hFF, 8'hFF);
        send_request(read_req(8'd8, 3'd7));
        send_request(read_req(8'd9, 3'd6));
        send_request(read_req(8'd15, 3'd0));
        send_request(read_req(8'd1, 3'd1));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_config(8'hFF, 8'd8, 8'd8);
                    idle_pct <= 15;
                end
                1:
                begin
                    // long stretch with no idling on either side
                    write_config(8'($urandom_range(255)), 8'd4, 8'd8);
                    idle_pct <= 0;
                end
                2:
                begin
                    write_config(8'($urandom_range(255)), 8'($urandom_range(1, 15)),
                                 8'($urandom_range(1, 15)));
                    idle_pct <= 15;
                    hold_req <= 1'b1;
                end
                default:
                begin
                    write_config(8'($urandom_range(255)), 8'd8, 8'($urandom_range(1, 8)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_request(random_item());
            end
        end

        wait_drained();
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d requests and %0d result items over %0d register settings",
                 request_count, result_count, settings_used);
        $display("results compared in order field by field, %0d mismatches", fail_count);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
